>>> rtl/row_edge_run_centroid_thinning_unit_defines.svh
// Assertion macros used by the top level of the row edge thinning unit.
`ifndef ROW_EDGE_RUN_CENTROID_THINNING_UNIT_DEFINES_SVH
`define ROW_EDGE_RUN_CENTROID_THINNING_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define RERCT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Condition must never be true outside reset.
`define RERCT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RERCT_ASSERT(lbl, clk, rst_n, prop, msg)
`define RERCT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

>>> rtl/rerct_pkg.sv
// Package with the types, constants and helpers of the row edge thinning unit.
`default_nettype none
package rerct_pkg;
    localparam int ROW_WIDTH_DEF = 1024;
    localparam int PIX_W         = 16;
    localparam int COL_OUT_W     = 10;
    localparam int MARGIN_W      = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic signed [PIX_W-1:0] RUN_THR_RST  = 16'sd50;
    localparam logic signed [PIX_W-1:0] KEEP_THR_RST = 16'sd50;
    localparam logic [MARGIN_W-1:0]     MARGIN_RST   = 8'd5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_POLARITY = 2'd0,
        REG_RUN_THR  = 2'd1,
        REG_KEEP_THR = 2'd2,
        REG_MARGIN   = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_MAX,
        ST_SUM,
        ST_DIV,
        ST_FETCH
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic start_max;
        logic start_sum;
        logic start_div;
        logic fetch;
        logic emit;
    } dp_cmd_t;

    typedef struct packed {
        logic run_done;
        logic scan_idle;
        logic div_busy;
        logic out_full;
    } dp_status_t;

    // Strict comparison in the direction set by the polarity bit.
    function automatic logic passes(input logic pol, input logic signed [PIX_W-1:0] v,
                                    input logic signed [PIX_W-1:0] t);
        passes = pol ? (v < t) : (v > t);
    endfunction
endpackage
`default_nettype wire

>>> rtl/row_edge_run_centroid_thinning_unit.sv
// Top level of the row edge thinning unit: controller and datapath.
// Usage:
// Gradient pixels of a row enter one per transfer on the s_ channel
// (s_pixel_value, s_last_in_row). Runs of pixels beyond the run threshold
// are buffered; at run end the unit emits at most one thinned edge on the
// m_ channel (m_edge_column, m_edge_value).
// A pixel that does not end a run leaves s_ready high, so such pixels are
// taken one per cycle. After a pixel that ends a run, s_ready stays low for
// two scans of the run store at one read a cycle (extreme, then weighted
// sums through a four stage pipeline) and a restoring divider that yields
// one quotient bit per cycle, then while the centre pixel is read and until
// the output register is free; m_valid rises in the cycle after the load.
// Reset (aresetn low, synchronous) clears the run tracking, the column
// counter, the output valid flag and loads the register defaults.
// The run store needs no clearing pass.
// A stalled receiver holds the result in the output register; the next
// pixel is still taken, and only a second result waits for the transfer.
// Configuration writes via cfg_we/cfg_index/cfg_wdata take effect at once.
`default_nettype none
`include "row_edge_run_centroid_thinning_unit_defines.svh"
module row_edge_run_centroid_thinning_unit #(
    parameter int ROW_WIDTH = rerct_pkg::ROW_WIDTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_we,
    input  wire logic [rerct_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [rerct_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic signed [rerct_pkg::PIX_W-1:0] s_pixel_value,
    input  wire logic                               s_last_in_row,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [rerct_pkg::COL_OUT_W-1:0]         m_edge_column,
    output logic signed [rerct_pkg::PIX_W-1:0]      m_edge_value
);
    rerct_pkg::dp_cmd_t    cmd;
    rerct_pkg::dp_status_t status;

    // The controller steps through the run end sequence.
    rerct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds all storage and arithmetic.
    rerct_dp #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_pixel_value (s_pixel_value),
        .s_last_in_row (s_last_in_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_edge_column (m_edge_column),
        .m_edge_value  (m_edge_value),
        .cmd           (cmd),
        .status        (status)
    );

    // Input is never taken while the divider works.
    `RERCT_NEVER(a_no_accept_in_div, aclk, aresetn, status.div_busy && s_ready,
                 "input ready during division")
    // A result is only loaded into a free output register.
    `RERCT_NEVER(a_emit_free, aclk, aresetn, cmd.emit && status.out_full,
                 "emit while output register is full")
    // A new result appears only after an emit command.
    `RERCT_ASSERT(a_valid_from_emit, aclk, aresetn, $rose(m_valid) |-> $past(cmd.emit),
                  "result valid without emit")
endmodule
`default_nettype wire

>>> rtl/rerct_ram.sv
// Generic single write port RAM with a registered read port.
`default_nettype none
module rerct_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/rerct_div.sv
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none
module rerct_div #(
    parameter int NW = 30,
    parameter int DW = 20,
    parameter int QW = 10
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic [QW-1:0]      quot
);
    localparam int CNTW = $clog2(QW + 1);

    logic [NW-1:0]   rem_reg, rem_next;
    logic [NW-1:0]   dsh_reg, dsh_next;
    logic [QW-1:0]   q_reg, q_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic            busy_reg, busy_next;
    logic            ge;

    always_comb begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        ge        = rem_reg >= dsh_reg;
        if (start) begin
            rem_next  = num;
            dsh_next  = NW'(den) << (QW - 1);
            q_next    = '0;
            cnt_next  = CNTW'(QW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? (rem_reg - dsh_reg) : rem_reg;
            q_next   = QW'({q_reg, ge});
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end

    assign busy = busy_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

>>> rtl/rerct_ctrl.sv
// Controller state machine that sequences the run end passes.
`default_nettype none
module rerct_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire rerct_pkg::dp_status_t status,
    output rerct_pkg::dp_cmd_t        cmd
);
    rerct_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rerct_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            rerct_pkg::ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid && status.run_done) begin
                    state_next = rerct_pkg::ST_START;
                end
            end
            rerct_pkg::ST_START: begin
                cmd.start_max = 1'b1;
                state_next    = rerct_pkg::ST_MAX;
            end
            rerct_pkg::ST_MAX: begin
                if (status.scan_idle) begin
                    cmd.start_sum = 1'b1;
                    state_next    = rerct_pkg::ST_SUM;
                end
            end
            rerct_pkg::ST_SUM: begin
                if (status.scan_idle) begin
                    cmd.start_div = 1'b1;
                    state_next    = rerct_pkg::ST_DIV;
                end
            end
            rerct_pkg::ST_DIV: begin
                if (!status.div_busy) begin
                    cmd.fetch  = 1'b1;
                    state_next = rerct_pkg::ST_FETCH;
                end
            end
            rerct_pkg::ST_FETCH: begin
                if (!status.out_full) begin
                    cmd.emit   = 1'b1;
                    state_next = rerct_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rerct_pkg::ST_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/rerct_dp.sv
// Datapath: registers, run tracking, run store, weighted scans and output register.
`default_nettype none
module rerct_dp #(
    parameter int ROW_WIDTH = rerct_pkg::ROW_WIDTH_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_we,
    input  wire logic [rerct_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rerct_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  wire logic signed [rerct_pkg::PIX_W-1:0]    s_pixel_value,
    input  wire logic                                  s_last_in_row,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [rerct_pkg::COL_OUT_W-1:0]            m_edge_column,
    output logic signed [rerct_pkg::PIX_W-1:0]         m_edge_value,
    input  wire rerct_pkg::dp_cmd_t                    cmd,
    output rerct_pkg::dp_status_t                      status
);
    localparam int AW   = $clog2(ROW_WIDTH);
    localparam int PW   = rerct_pkg::PIX_W;
    localparam int MW   = rerct_pkg::MARGIN_W;
    localparam int SW   = 2 * AW + 9;
    localparam int WSW  = AW + 9;
    localparam int NW   = SW + 1;
    localparam int DW   = WSW + 1;
    localparam int PRW  = MW + AW;

    // Configuration registers.
    logic                 polarity_reg;
    logic signed [PW-1:0] run_thr_reg;
    logic signed [PW-1:0] keep_thr_reg;
    logic [MW-1:0]        margin_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            polarity_reg <= 1'b0;
            run_thr_reg  <= rerct_pkg::RUN_THR_RST;
            keep_thr_reg <= rerct_pkg::KEEP_THR_RST;
            margin_reg   <= rerct_pkg::MARGIN_RST;
        end else if (cfg_we) begin
            unique case (rerct_pkg::cfg_reg_t'(cfg_index))
                rerct_pkg::REG_POLARITY: polarity_reg <= cfg_wdata[0];
                rerct_pkg::REG_RUN_THR:  run_thr_reg  <= cfg_wdata;
                rerct_pkg::REG_KEEP_THR: keep_thr_reg <= cfg_wdata;
                rerct_pkg::REG_MARGIN:   margin_reg   <= cfg_wdata[MW-1:0];
                default: ;
            endcase
        end
    end

    // Run tracking on each accepted pixel.
    logic [AW-1:0] col_reg, col_next;
    logic [AW-1:0] run_start_reg, run_start_next;
    logic          in_run_reg, in_run_next;
    logic [AW-1:0] rs_reg, rs_next;
    logic [AW-1:0] last_reg, last_next;
    logic          pix_pass, row_end, run_done;

    always_comb begin
        pix_pass       = rerct_pkg::passes(polarity_reg, s_pixel_value, run_thr_reg);
        row_end        = s_last_in_row || (col_reg == AW'(ROW_WIDTH - 1));
        in_run_next    = in_run_reg;
        run_start_next = run_start_reg;
        rs_next        = rs_reg;
        last_next      = last_reg;
        run_done       = 1'b0;
        if (!in_run_reg) begin
            if (pix_pass) begin
                in_run_next    = 1'b1;
                run_start_next = col_reg;
            end
        end else if (!pix_pass) begin
            run_done    = 1'b1;
            rs_next     = run_start_reg;
            last_next   = col_reg - AW'(1);
            in_run_next = 1'b0;
        end
        if (row_end && in_run_next) begin
            run_done    = 1'b1;
            rs_next     = run_start_next;
            last_next   = col_reg;
            in_run_next = 1'b0;
        end
        col_next = row_end ? '0 : col_reg + AW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg       <= '0;
            run_start_reg <= '0;
            in_run_reg    <= 1'b0;
        end else if (cmd.accept) begin
            col_reg       <= col_next;
            run_start_reg <= run_start_next;
            in_run_reg    <= in_run_next;
        end
        if (cmd.accept) begin
            rs_reg   <= rs_next;
            last_reg <= last_next;
        end
    end

    // Scan address generator over the buffered run.
    logic          scan_active_reg;
    logic [AW-1:0] scan_addr_reg;
    logic [AW-1:0] scan_off_reg;
    logic          pass_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_active_reg <= 1'b0;
            pass_sum_reg    <= 1'b0;
        end else if (cmd.start_max || cmd.start_sum) begin
            scan_active_reg <= 1'b1;
            pass_sum_reg    <= cmd.start_sum;
        end else if (scan_active_reg && scan_addr_reg == last_reg) begin
            scan_active_reg <= 1'b0;
        end
        if (cmd.start_max || cmd.start_sum) begin
            scan_addr_reg <= rs_reg;
            scan_off_reg  <= '0;
        end else if (scan_active_reg) begin
            scan_addr_reg <= scan_addr_reg + AW'(1);
            scan_off_reg  <= scan_off_reg + AW'(1);
        end
    end

    // Run store.
    logic [AW-1:0]        c_addr;
    logic [PW-1:0]        rdata;
    logic signed [PW-1:0] rval;

    rerct_ram #(
        .WIDTH (PW),
        .DEPTH (ROW_WIDTH)
    ) u_store (
        .aclk  (aclk),
        .we    (cmd.accept),
        .waddr (col_reg),
        .wdata (s_pixel_value),
        .re    (scan_active_reg || cmd.fetch),
        .raddr (cmd.fetch ? c_addr : scan_addr_reg),
        .rdata (rdata)
    );
    assign rval = rdata;

    // Scan pipeline: read, weight, multiply, accumulate.
    logic                 v1_reg, v2_reg, v3_reg;
    logic                 first1_reg;
    logic [AW-1:0]        off1_reg, off2_reg;
    logic signed [PW-1:0] ext_reg;
    logic [MW-1:0]        w2_reg, w3_reg;
    logic [PRW-1:0]       prod_reg;
    logic [SW-1:0]        sum_reg;
    logic [WSW-1:0]       wsum_reg;
    logic [MW-1:0]        m_eff;
    logic [PW:0]          gap;
    logic [MW-1:0]        weight;

    always_comb begin
        m_eff  = (margin_reg == '0) ? MW'(1) : margin_reg;
        gap    = polarity_reg ? ({rval[PW-1], rval} - {ext_reg[PW-1], ext_reg})
                              : ({ext_reg[PW-1], ext_reg} - {rval[PW-1], rval});
        weight = (gap <= (PW+1)'(m_eff)) ? (m_eff - gap[MW-1:0]) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= scan_active_reg;
            v2_reg <= v1_reg && pass_sum_reg;
            v3_reg <= v2_reg;
        end
        first1_reg <= scan_off_reg == '0;
        off1_reg   <= scan_off_reg;
        if (v1_reg && !pass_sum_reg &&
            (first1_reg || rerct_pkg::passes(polarity_reg, rval, ext_reg))) begin
            ext_reg <= rval;
        end
        w2_reg   <= weight;
        off2_reg <= off1_reg;
        prod_reg <= PRW'(w2_reg) * PRW'(off2_reg);
        w3_reg   <= w2_reg;
        if (cmd.start_sum) begin
            sum_reg  <= '0;
            wsum_reg <= '0;
        end else if (v3_reg) begin
            sum_reg  <= sum_reg + SW'(prod_reg);
            wsum_reg <= wsum_reg + WSW'(w3_reg);
        end
    end

    // Rounded division of the weighted offset sum.
    logic [AW-1:0] quot;
    logic          div_busy;

    rerct_div #(
        .NW (NW),
        .DW (DW),
        .QW (AW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_div),
        .num     ({sum_reg, 1'b0} + NW'(wsum_reg)),
        .den     ({wsum_reg, 1'b0}),
        .busy    (div_busy),
        .quot    (quot)
    );

    assign c_addr = rs_reg + ((wsum_reg == '0) ? '0 : quot);

    // Output register.
    logic [AW-1:0]             c_reg;
    logic [AW+9:0]             c_wide;
    logic                      out_valid_reg;
    logic [rerct_pkg::COL_OUT_W-1:0] out_col_reg;
    logic signed [PW-1:0]      out_val_reg;

    assign c_wide = (AW+10)'(c_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit && rerct_pkg::passes(polarity_reg, rval, keep_thr_reg)) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.fetch) begin
            c_reg <= c_addr;
        end
        if (cmd.emit) begin
            out_col_reg <= c_wide[rerct_pkg::COL_OUT_W-1:0];
            out_val_reg <= rval;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_edge_column = out_col_reg;
    assign m_edge_value  = out_val_reg;

    assign status.run_done  = run_done;
    assign status.scan_idle = !scan_active_reg && !v1_reg && !v2_reg && !v3_reg;
    assign status.div_busy  = div_busy;
    assign status.out_full  = out_valid_reg;
endmodule
`default_nettype wire

>>> dv/row_edge_run_centroid_thinning_unit_tb.sv
// Testbench for the row edge thinning unit: directed rows, then random rows checked against a predictor.
`default_nettype none
module row_edge_run_centroid_thinning_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rerct_pkg::*;

    localparam int ROW_W = 1024;
    // Settling wait, meant to cover the hold-off after a run of the full row.
    localparam int SETTLE_CYCLES = 2200;

    typedef struct {
        logic [COL_OUT_W-1:0]    column;
        logic signed [PIX_W-1:0] value;
    } edge_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic signed [PIX_W-1:0] s_pixel_value = '0;
    logic                    s_last_in_row = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [COL_OUT_W-1:0]    m_edge_column;
    logic signed [PIX_W-1:0] m_edge_value;

    row_edge_run_centroid_thinning_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pixel_value(s_pixel_value), .s_last_in_row(s_last_in_row),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_edge_column(m_edge_column), .m_edge_value(m_edge_value)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Predictor state, a private copy of what the unit tracks.
    logic signed [PIX_W-1:0] row_pixels [ROW_W];
    int unsigned             col_pos;
    int unsigned             run_begin;
    bit                      run_open;
    bit                      cur_polarity;
    logic signed [PIX_W-1:0] cur_run_thr;
    logic signed [PIX_W-1:0] cur_keep_thr;
    logic [MARGIN_W-1:0]     cur_margin;

    edge_t edge_queue [$];
    int    fail_count = 0;

    // Idle percentages for the sender and the receiver; changed between phases.
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    function automatic bit beyond(logic signed [PIX_W-1:0] v, logic signed [PIX_W-1:0] t);
        return cur_polarity ? (v < t) : (v > t);
    endfunction

    // Weighted centroid of the run in columns [s, e), rounded half up.
    function automatic int unsigned run_centroid(int unsigned s, int unsigned e);
        int signed    extreme;
        int unsigned  m;
        int unsigned  d;
        longint unsigned wsum;
        longint unsigned osum;
        extreme = row_pixels[s];
        m = (cur_margin == 0) ? 1 : cur_margin;
        wsum = 0;
        osum = 0;
        for (int unsigned i = s + 1; i < e; i++) begin
            if (beyond(row_pixels[i], extreme[PIX_W-1:0])) extreme = row_pixels[i];
        end
        for (int unsigned i = s; i < e; i++) begin
            d = cur_polarity ? (int'(row_pixels[i]) - extreme) : (extreme - int'(row_pixels[i]));
            if (d <= m) begin
                wsum += m - d;
                osum += longint'(m - d) * (i - s);
            end
        end
        if (wsum == 0) return s;
        return s + int'((2 * osum + wsum) / (2 * wsum));
    endfunction

    // Advances the predictor by one pixel and queues the edge it yields, if any.
    task automatic predict_pixel(logic signed [PIX_W-1:0] v, bit last);
        int unsigned col;
        int unsigned rs;
        int unsigned re;
        int unsigned c;
        bit          row_end;
        bit          pass;
        bit          done;
        edge_t       e;
        col = (col_pos >= ROW_W) ? 0 : col_pos;
        row_end = last || (col >= ROW_W - 1);
        row_pixels[col] = v;
        pass = beyond(v, cur_run_thr);
        done = 1'b0;
        rs = 0;
        re = 0;
        if (run_begin >= ROW_W || run_begin > col) run_begin = col;
        if (!run_open) begin
            if (pass) begin
                run_open = 1'b1;
                run_begin = col;
            end
        end else if (!pass) begin
            done = 1'b1;
            rs = run_begin;
            re = col;
            run_open = 1'b0;
        end
        if (row_end && run_open) begin
            done = 1'b1;
            rs = run_begin;
            re = col + 1;
            run_open = 1'b0;
        end
        if (done && re > rs) begin
            c = run_centroid(rs, re);
            if (beyond(row_pixels[c], cur_keep_thr)) begin
                e.column = c[COL_OUT_W-1:0];
                e.value = row_pixels[c];
                edge_queue.push_back(e);
            end
        end
        col_pos = row_end ? 0 : col + 1;
    endtask

    // Sends one pixel after a random idle gap and updates the predictor on acceptance.
    // Valid stays high after the transfer until an idle cycle or the next drain.
    task automatic send_pixel(logic signed [PIX_W-1:0] v, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_value <= v;
        s_last_in_row <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_pixel(v, last);
    endtask

    // Waits until every expected edge has arrived and the unit has gone quiet.
    task automatic drain();
        s_valid <= 1'b0;
        while (edge_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_POLARITY: cur_polarity = data[0];
            REG_RUN_THR:  cur_run_thr = data;
            REG_KEEP_THR: cur_keep_thr = data;
            REG_MARGIN:   cur_margin = data[MARGIN_W-1:0];
        endcase
    endtask

    task automatic set_config(bit pol, int run_thr, int keep_thr, int unsigned marg);
        drain();
        write_reg(REG_POLARITY, CFG_DATA_W'(pol));
        write_reg(REG_RUN_THR, CFG_DATA_W'(run_thr));
        write_reg(REG_KEEP_THR, CFG_DATA_W'(keep_thr));
        write_reg(REG_MARGIN, CFG_DATA_W'(marg));
        cfg_we <= 1'b0;
    endtask

    // The receiver stalls at random; the stall rate follows the current phase.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every result transfer is compared with the oldest expected edge.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (edge_queue.size() == 0) begin
                $display("%0t: unexpected edge col=%0d value=%0d", $time,
                         m_edge_column, m_edge_value);
                fail_count++;
            end else begin
                edge_t exp_e;
                exp_e = edge_queue.pop_front();
                if (m_edge_column !== exp_e.column) begin
                    $display("%0t: edge_column expected %0d actual %0d", $time,
                             exp_e.column, m_edge_column);
                    fail_count++;
                end
                if (m_edge_value !== exp_e.value) begin
                    $display("%0t: edge_value expected %0d actual %0d", $time,
                             exp_e.value, m_edge_value);
                    fail_count++;
                end
            end
        end
    end

    // Directed: threshold and value extremes, run ending on a failing pixel and at
    // row end, and a run that starts on the final pixel.
    task automatic test_directed();
        send_pixel(16'sh7fff, 1'b0);
        send_pixel(16'sh7fff, 1'b0);
        send_pixel(16'sh8000, 1'b0);
        send_pixel(16'sd60, 1'b0);
        send_pixel(16'sd70, 1'b0);
        send_pixel(16'sd68, 1'b0);
        send_pixel(16'sd51, 1'b0);
        send_pixel(16'sd50, 1'b0);
        send_pixel(16'sd90, 1'b0);
        send_pixel(16'sd91, 1'b1);
        send_pixel(16'sd0, 1'b0);
        send_pixel(16'sd200, 1'b1);
        send_pixel(-16'sd1, 1'b1);
    endtask

    // Random rows: mostly short rows of bumps near the threshold, some raw noise.
    task automatic test_random_rows(int unsigned n_pixels);
        int unsigned sent;
        int unsigned len;
        int signed   base;
        int signed   v;
        sent = 0;
        while (sent < n_pixels) begin
            len = $urandom_range(24, 1);
            base = cur_polarity ? int'(cur_run_thr) - 20 : int'(cur_run_thr) + 20;
            for (int unsigned i = 0; i < len; i++) begin
                if ($urandom_range(9) == 0) v = int'($urandom_range(65535)) - 32768;
                else v = base + int'($urandom_range(60)) - 30;
                if (v > 32767) v = 32767;
                if (v < -32768) v = -32768;
                send_pixel(PIX_W'(v), i == len - 1);
                sent++;
            end
        end
    endtask

    initial begin
        cur_polarity = 1'b0;
        cur_run_thr = RUN_THR_RST;
        cur_keep_thr = KEEP_THR_RST;
        cur_margin = MARGIN_RST;
        col_pos = 0;
        run_begin = 0;
        run_open = 1'b0;
        foreach (row_pixels[i]) row_pixels[i] = '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        set_config(1'b1, -32768, 32767, 0);
        test_directed();
        set_config(1'b1, 32767, -32768, 255);
        test_directed();
        set_config(1'b0, -32768, 32767, 1);
        test_directed();

        set_config(1'b0, 100, 90, 8);
        test_random_rows(200);
        send_idle_pct = 56;
        set_config(1'b1, -100, -95, 3);
        test_random_rows(200);
        send_idle_pct = 0;
        recv_stall_pct = 56;
        set_config(1'b0, -7, 0, 255);
        test_random_rows(200);
        send_idle_pct = 36;
        recv_stall_pct = 36;
        set_config(1'b1, 500, 480, 0);
        test_random_rows(200);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (fail_count == 0) begin
            $display("[row_edge_run_centroid_thinning_unit] OK");
        end else begin
            $display("[row_edge_run_centroid_thinning_unit] ERROR");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("[row_edge_run_centroid_thinning_unit] ERROR");
        $finish;
    end
endmodule
`default_nettype wire
